### src/smma_pkg.sv
// ----------------------------------------------------------------------------
// smma_pkg
// shared types and constants of the scaled matrix multiply-add block
// ----------------------------------------------------------------------------
package smma_pkg;

    localparam logic [1:0] FUNC_LOAD_A   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B   = 2'd1;
    localparam logic [1:0] FUNC_LOAD_C   = 2'd2;
    localparam logic [1:0] FUNC_COMPUTE  = 2'd3;

    localparam logic [2:0] REG_TRANS_A   = 3'd0;
    localparam logic [2:0] REG_TRANS_B   = 3'd1;
    localparam logic [2:0] REG_ALPHA     = 3'd2;
    localparam logic [2:0] REG_BETA      = 3'd3;
    localparam logic [2:0] REG_ROWS      = 3'd4;
    localparam logic [2:0] REG_INNER     = 3'd5;
    localparam logic [2:0] REG_COLS      = 3'd6;
    localparam logic [2:0] REG_ADDEND    = 3'd7;

    localparam int MAX_RESULTS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_ADDEND,
        ST_EMIT,
        ST_ERROR
    } t_state;

    // memory access request from the sequencer
    typedef struct packed {
        logic       rd_en;
        logic [7:0] a_addr;
        logic [7:0] b_addr;
        logic [7:0] c_addr;
    } t_mem_rd;

endpackage

### src/scaled_matrix_multiply_add.sv
// ----------------------------------------------------------------------------
// scaled_matrix_multiply_add
// C = alpha*op(A)*op(B) + beta*C if addend on, one output row per compute item
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// item      in         i_start & !o_busy         func, row, col, elem_value
// config    in         i_cfg_valid & o_cfg_ready index, data
// result    out        o_strobe (one cycle)      col, value, last, error
//
// a load item is written when accepted and leaves busy low; a compute item keeps busy
// high, for each column, through n reads on the single shared multiply-accumulate, a
// drain for the read and product registers, then scale, addend and emit.
// an out-of-range row gives its error result in the cycle after the item.
// reset is synchronous active low and clears control and config only.
// results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module scaled_matrix_multiply_add
    import smma_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_func,
    input  logic [3:0]         i_row_index,
    input  logic [3:0]         i_col_index,
    input  logic signed [15:0] i_elem_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_strobe,
    output logic [3:0]         o_out_col,
    output logic signed [31:0] o_out_value,
    output logic               o_row_last,
    output logic               o_range_error
);

    localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = (MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1;
    localparam int KMAX = (MAX_DIM < MAX_RESULTS) ? MAX_DIM : MAX_RESULTS;

    // configuration
    logic               r_trans_a, r_trans_b, r_use_add;
    logic signed [15:0] r_alpha, r_beta;
    logic [4:0]         r_rows, r_inner, r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_a <= 1'b0;
            r_trans_b <= 1'b0;
            r_alpha   <= 16'sd256;
            r_beta    <= 16'sd0;
            r_rows    <= 5'd1;
            r_inner   <= 5'd1;
            r_cols    <= 5'd1;
            r_use_add <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TRANS_A: r_trans_a <= i_cfg_data[0];
                REG_TRANS_B: r_trans_b <= i_cfg_data[0];
                REG_ALPHA:   r_alpha   <= i_cfg_data;
                REG_BETA:    r_beta    <= i_cfg_data;
                REG_ROWS:    r_rows    <= i_cfg_data[4:0];
                REG_INNER:   r_inner   <= i_cfg_data[4:0];
                REG_COLS:    r_cols    <= i_cfg_data[4:0];
                REG_ADDEND:  r_use_add <= i_cfg_data[0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // clamped dimensions
    function automatic logic [8:0] clamp(input logic [4:0] d, input int hi);
        logic [8:0] v;
        v = {4'd0, d};
        if (v == 9'd0) v = 9'd1;
        if (v > 9'(hi)) v = 9'(hi);
        return v;
    endfunction

    logic [8:0] n_m, n_n, n_k;
    assign n_m = clamp(r_rows, MAX_DIM);
    assign n_n = clamp(r_inner, MAX_DIM);
    assign n_k = clamp(r_cols, KMAX);

    // sequencer state
    t_state     r_state, n_state;
    logic [DW-1:0] r_row;
    logic [8:0] r_i, r_c;
    logic       r_vld1, r_vld2;
    logic       n_accept, n_load, n_bad;
    t_mem_rd    n_rd;
    logic       n_use_c;

    assign n_accept = i_start && !o_busy;
    assign n_load   = n_accept && (i_func != FUNC_COMPUTE);
    assign n_bad    = {5'd0, i_row_index} >= n_m;
    assign n_use_c  = r_use_add && (r_beta != 16'sd0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (n_accept && i_func == FUNC_COMPUTE)
                           n_state = n_bad ? ST_ERROR : ST_MAC;
            ST_MAC:    if (r_i + 9'd1 == n_n) n_state = ST_DRAIN;
            ST_DRAIN:  if (!r_vld1 && !r_vld2) n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_ADDEND;
            ST_ADDEND: n_state = ST_EMIT;
            ST_EMIT:   n_state = (r_c + 9'd1 == n_k) ? ST_IDLE : ST_MAC;
            ST_ERROR:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // memory addresses
    always_comb begin
        logic [AW-1:0] ai, bi;
        ai = r_trans_a ? AW'(r_i * 9'(MAX_DIM) + 9'(r_row))
                       : AW'(9'(r_row) * 9'(MAX_DIM) + r_i);
        bi = r_trans_b ? AW'(r_c * 9'(MAX_DIM) + r_i)
                       : AW'(r_i * 9'(MAX_DIM) + r_c);
        n_rd.rd_en  = (r_state == ST_MAC) || (r_state == ST_DRAIN);
        n_rd.a_addr = 8'(ai);
        n_rd.b_addr = 8'(bi);
        n_rd.c_addr = 8'(AW'(9'(r_row) * 9'(MAX_DIM) + r_c));
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vld1  <= 1'b0;
            r_vld2  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld1  <= (r_state == ST_MAC);
            r_vld2  <= r_vld1;
        end
        if (r_state == ST_IDLE) begin
            r_row <= DW'(i_row_index);
            r_i   <= '0;
            r_c   <= '0;
        end else if (r_state == ST_MAC) begin
            r_i <= r_i + 9'd1;
        end else if (r_state == ST_EMIT) begin
            r_i <= '0;
            r_c <= r_c + 9'd1;
        end
    end

    logic signed [15:0] w_a, w_b, w_c;
    logic signed [31:0] w_value;
    logic               w_load_ok;

    assign w_load_ok = n_load && ({1'b0, i_row_index} < 5'(MAX_DIM))
                              && ({1'b0, i_col_index} < 5'(MAX_DIM));

    smma_store #(.AW(AW)) u_store (
        .i_clk    (i_clk),
        .i_we     (w_load_ok),
        .i_wsel   (i_func),
        .i_waddr  (AW'(9'(i_row_index) * 9'(MAX_DIM) + 9'(i_col_index))),
        .i_wdata  (i_elem_value),
        .i_re     (n_rd.rd_en),
        .i_a_addr (AW'(n_rd.a_addr)),
        .i_b_addr (AW'(n_rd.b_addr)),
        .i_c_addr (AW'(n_rd.c_addr)),
        .o_a_data (w_a),
        .o_b_data (w_b),
        .o_c_data (w_c)
    );

    smma_mac u_mac (
        .i_clk      (i_clk),
        .i_clr      (r_state == ST_IDLE || r_state == ST_EMIT),
        .i_acc_en   (r_vld2),
        .i_scale_en (r_state == ST_SCALE),
        .i_add_en   (r_state == ST_ADDEND),
        .i_use_c    (n_use_c),
        .i_a        (w_a),
        .i_b        (w_b),
        .i_c        (w_c),
        .i_alpha    (r_alpha),
        .i_beta     (r_beta),
        .o_value    (w_value)
    );

    // outputs
    always_comb begin
        o_busy        = (r_state != ST_IDLE);
        o_strobe      = (r_state == ST_EMIT) || (r_state == ST_ERROR);
        o_out_col     = (r_state == ST_EMIT) ? r_c[3:0] : 4'd0;
        o_out_value   = (r_state == ST_EMIT) ? w_value : 32'sd0;
        o_row_last    = (r_state == ST_ERROR) || (r_c + 9'd1 == n_k);
        o_range_error = (r_state == ST_ERROR);
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy) else $error("strobe while idle");
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_range_error |-> o_row_last) else $error("error result not last");
    a_mac_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> !o_strobe) else $error("strobe during mac");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_row_last) |=> !o_busy) else $error("busy after last");
`endif

endmodule

### src/smma_store.sv
// ----------------------------------------------------------------------------
// smma_store
// three element memories for A, B and the addend C, with registered reads
// ----------------------------------------------------------------------------
module smma_store
    import smma_pkg::*;
#(
    parameter int AW = 8
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [1:0]          i_wsel,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [15:0]  i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_a_addr,
    input  logic [AW-1:0]       i_b_addr,
    input  logic [AW-1:0]       i_c_addr,
    output logic signed [15:0]  o_a_data,
    output logic signed [15:0]  o_b_data,
    output logic signed [15:0]  o_c_data
);

    logic signed [15:0] r_mem_a [2**AW];
    logic signed [15:0] r_mem_b [2**AW];
    logic signed [15:0] r_mem_c [2**AW];

    // writes
    always_ff @(posedge i_clk) begin
        if (i_we && i_wsel == FUNC_LOAD_A) r_mem_a[i_waddr] <= i_wdata;
        if (i_we && i_wsel == FUNC_LOAD_B) r_mem_b[i_waddr] <= i_wdata;
        if (i_we && i_wsel == FUNC_LOAD_C) r_mem_c[i_waddr] <= i_wdata;
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_a_data <= r_mem_a[i_a_addr];
            o_b_data <= r_mem_b[i_b_addr];
            o_c_data <= r_mem_c[i_c_addr];
        end
    end

endmodule

### src/smma_mac.sv
// ----------------------------------------------------------------------------
// smma_mac
// shared multiply-accumulate datapath with alpha scaling, addend and saturation
// ----------------------------------------------------------------------------
module smma_mac
    import smma_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_clr,
    input  logic                i_acc_en,
    input  logic                i_scale_en,
    input  logic                i_add_en,
    input  logic                i_use_c,
    input  logic signed [15:0]  i_a,
    input  logic signed [15:0]  i_b,
    input  logic signed [15:0]  i_c,
    input  logic signed [15:0]  i_alpha,
    input  logic signed [15:0]  i_beta,
    output logic signed [31:0]  o_value
);

    logic signed [31:0] r_prod;
    logic signed [35:0] r_acc;
    logic signed [43:0] r_total;
    logic signed [51:0] n_scaled;
    logic signed [31:0] n_cterm;
    logic signed [44:0] n_sum;

    // product register, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_clr) r_acc <= '0;
        else if (i_acc_en) r_acc <= r_acc + 36'(r_prod);
    end

    assign n_scaled = r_acc * i_alpha + 52'sd128;
    assign n_cterm  = i_use_c ? i_beta * i_c : 32'sd0;
    assign n_sum    = 45'(r_total) + 45'(n_cterm);

    // scale with round half up, then add beta*c
    always_ff @(posedge i_clk) begin
        if (i_scale_en) r_total <= n_scaled[51:8];
        else if (i_add_en) r_total <= 44'(n_sum);
    end

    // saturate to q15.16
    always_comb begin
        if (r_total > 44'sd2147483647) o_value = 32'sh7fffffff;
        else if (r_total < -44'sd2147483648) o_value = 32'sh80000000;
        else o_value = r_total[31:0];
    end

endmodule

### tb/scaled_matrix_multiply_add_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_matrix_multiply_add_tb
// self-checking bench: loads matrices, computes rows under several register
// settings and compares every result against a behavioral predictor
// ----------------------------------------------------------------------------
module scaled_matrix_multiply_add_tb;
    import smma_pkg::*;

    localparam int DIM       = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 40;

    typedef struct packed {
        logic [3:0]         col;
        logic signed [31:0] value;
        logic               last;
        logic               err;
    } t_result;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] value;
        logic        typed;
        t_result     want;
    } t_stim;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [1:0]         i_func = '0;
    logic [3:0]         i_row_index = '0;
    logic [3:0]         i_col_index = '0;
    logic signed [15:0] i_elem_value = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               o_strobe;
    logic [3:0]         o_out_col;
    logic signed [31:0] o_out_value;
    logic               o_row_last;
    logic               o_range_error;

    scaled_matrix_multiply_add #(.MAX_DIM(DIM)) i_dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] mat_a [DIM*DIM];
    logic signed [15:0] mat_b [DIM*DIM];
    logic signed [15:0] mat_c [DIM*DIM];
    logic        tr_a, tr_b, add_on;
    logic signed [15:0] alpha, beta;
    logic [4:0]  rows_m, inner_n, cols_k;

    t_result expected_results [$];
    int  fail_count = 0;
    int  result_count = 0;
    int  item_count = 0;
    int  compute_count = 0;
    int  idle_cycles = 0;
    bit  typed_pending = 0;
    t_result typed_want;

    function automatic int clamp_dim(logic [4:0] d);
        if (d == 0) return 1;
        if (d > DIM) return DIM;
        return d;
    endfunction

    // apply one item to the predictor
    task automatic predict_item(logic [1:0] f, logic [3:0] r, logic [3:0] c,
                                logic signed [15:0] v);
        int m, n, k, col, i, ai, bi;
        longint acc, total;
        t_result res;
        if (f != FUNC_COMPUTE) begin
            if (f == FUNC_LOAD_A) mat_a[r*DIM+c] = v;
            else if (f == FUNC_LOAD_B) mat_b[r*DIM+c] = v;
            else mat_c[r*DIM+c] = v;
            return;
        end
        m = clamp_dim(rows_m);
        n = clamp_dim(inner_n);
        k = clamp_dim(cols_k);
        if (r >= m) begin
            res = '{col: 4'd0, value: 32'sd0, last: 1'b1, err: 1'b1};
            expected_results.push_back(res);
            return;
        end
        for (col = 0; col < k; col++) begin
            acc = 0;
            for (i = 0; i < n; i++) begin
                ai = tr_a ? i*DIM + r : r*DIM + i;
                bi = tr_b ? col*DIM + i : i*DIM + col;
                acc += longint'(mat_a[ai]) * longint'(mat_b[bi]);
            end
            total = (acc * longint'(alpha) + 128) >>> 8;
            if (add_on && beta != 0)
                total += longint'(beta) * longint'(mat_c[r*DIM+col]);
            if (total > 64'sd2147483647) total = 64'sd2147483647;
            if (total < -64'sd2147483648) total = -64'sd2147483648;
            res.col = col[3:0];
            res.value = total[31:0];
            res.last = (col + 1 == k);
            res.err = 1'b0;
            expected_results.push_back(res);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            result_count++;
            if (expected_results.size() == 0) begin
                $error("unexpected result col=%0d value=%0d", o_out_col, o_out_value);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (typed_pending) begin
                    typed_pending = 0;
                    if (typed_want != want) begin
                        $error("typed row: expected %p, predictor %p", typed_want, want);
                        fail_count++;
                    end
                end
                if (o_out_col !== want.col) begin
                    $error("out_col: expected %0d, actual %0d", want.col, o_out_col);
                    fail_count++;
                end
                if (o_out_value !== want.value) begin
                    $error("out_value: expected %0d, actual %0d", want.value, o_out_value);
                    fail_count++;
                end
                if (o_row_last !== want.last) begin
                    $error("row_last: expected %0d, actual %0d", want.last, o_row_last);
                    fail_count++;
                end
                if (o_range_error !== want.err) begin
                    $error("range_error: expected %0d, actual %0d", want.err, o_range_error);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted traffic
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_TRANS_A: tr_a    = data[0];
            REG_TRANS_B: tr_b    = data[0];
            REG_ALPHA:   alpha   = data;
            REG_BETA:    beta    = data;
            REG_ROWS:    rows_m  = data[4:0];
            REG_INNER:   inner_n = data[4:0];
            REG_COLS:    cols_k  = data[4:0];
            default:     add_on  = data[0];
        endcase
    endtask

    // drive one item and hold until accepted
    task automatic send_item(logic [1:0] f, logic [3:0] r, logic [3:0] c,
                             logic [15:0] v);
        i_func       <= f;
        i_row_index  <= r;
        i_col_index  <= c;
        i_elem_value <= v;
        i_start      <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_item(f, r, c, v);
        item_count++;
        if (f == FUNC_COMPUTE) compute_count++;
    endtask

    task automatic idle_gap(int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // let every expected result arrive, then the block settle
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    // sender stops before the register writes, valid drops after the last one
    task automatic write_all(logic ta, logic tb, logic [15:0] al, logic [15:0] be,
                             logic [4:0] m, logic [4:0] n, logic [4:0] k, logic ad);
        i_start <= 1'b0;
        write_reg(REG_TRANS_A, {15'd0, ta});
        write_reg(REG_TRANS_B, {15'd0, tb});
        write_reg(REG_ALPHA, al);
        write_reg(REG_BETA, be);
        write_reg(REG_ROWS, {11'd0, m});
        write_reg(REG_INNER, {11'd0, n});
        write_reg(REG_COLS, {11'd0, k});
        write_reg(REG_ADDEND, {15'd0, ad});
        i_cfg_valid <= 1'b0;
    endtask

    // fill the leading square of each store, later settings read only inside it
    task automatic fill_stores(bit extreme, int span);
        logic [15:0] v;
        for (int r = 0; r < span; r++)
            for (int c = 0; c < span; c++)
                for (int f = 0; f < 3; f++) begin
                    v = extreme ? (($urandom_range(0, 1)) ? 16'h7fff : 16'h8000)
                                : 16'($urandom);
                    send_item(f[1:0], r[3:0], c[3:0], v);
                    if ($urandom_range(0, 15) == 0) idle_gap($urandom_range(1, 4));
                end
    endtask

    // directed stimulus
    t_stim directed [] = '{
        '{FUNC_LOAD_A,  4'd0, 4'd0, 16'h0100, 1'b0, '0},
        '{FUNC_LOAD_B,  4'd0, 4'd0, 16'h0200, 1'b0, '0},
        '{FUNC_LOAD_C,  4'd0, 4'd0, 16'h7fff, 1'b0, '0},
        '{FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000, 1'b1, '{4'd0, 32'sh0002_0000, 1'b1, 1'b0}},
        '{FUNC_COMPUTE, 4'd1, 4'd0, 16'h0000, 1'b1, '{4'd0, 32'sd0, 1'b1, 1'b1}},
        '{FUNC_COMPUTE, 4'd15, 4'd15, 16'hffff, 1'b1, '{4'd0, 32'sd0, 1'b1, 1'b1}},
        '{FUNC_LOAD_A,  4'd0, 4'd0, 16'h8000, 1'b0, '0},
        '{FUNC_LOAD_B,  4'd0, 4'd0, 16'h8000, 1'b0, '0},
        '{FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000, 1'b1, '{4'd0, 32'sh4000_0000, 1'b1, 1'b0}},
        '{FUNC_LOAD_B,  4'd0, 4'd0, 16'h7fff, 1'b0, '0},
        '{FUNC_COMPUTE, 4'd0, 4'd9, 16'h1234, 1'b0, '0},
        '{FUNC_LOAD_A,  4'd15, 4'd15, 16'h7fff, 1'b0, '0},
        '{FUNC_LOAD_C,  4'd15, 4'd15, 16'h8000, 1'b0, '0}
    };

    initial begin
        tr_a = 0; tr_b = 0; add_on = 0;
        alpha = 16'sd256; beta = 0;
        rows_m = 1; inner_n = 1; cols_k = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults first, typed rows checked against the table
        foreach (directed[j]) begin
            if (directed[j].typed && directed[j].func == FUNC_COMPUTE) begin
                if (typed_pending || expected_results.size() != 0) begin
                    i_start <= 1'b0;
                    while (typed_pending || expected_results.size() != 0)
                        @(posedge i_clk);
                end
                typed_want = directed[j].want;
                typed_pending = 1;
            end
            send_item(directed[j].func, directed[j].row, directed[j].col,
                      directed[j].value);
        end
        drain();

        // addend on with extreme beta, saturating small matrices
        write_all(1'b0, 1'b0, 16'h7fff, 16'h7fff, 5'd2, 5'd2, 5'd2, 1'b1);
        fill_stores(1, 2);
        for (int r = 0; r < 2; r++) send_item(FUNC_COMPUTE, r[3:0], 4'd0, 16'h0);
        send_item(FUNC_COMPUTE, 4'd15, 4'd0, 16'h0);
        drain();
        write_all(1'b1, 1'b1, 16'h8000, 16'h8000, 5'd2, 5'd2, 5'd2, 1'b1);
        send_item(FUNC_COMPUTE, 4'd1, 4'd0, 16'h0);
        send_item(FUNC_COMPUTE, 4'd0, 4'd0, 16'h0);
        drain();

        // random phases over mixed settings, reads stay inside the filled square
        fill_stores(0, 4);
        for (int ph = 0; ph < 5; ph++) begin
            write_all($urandom_range(0, 1), $urandom_range(0, 1), 16'($urandom),
                      (ph == 2) ? 16'h0 : 16'($urandom),
                      ph == 0 ? 5'd0 : (ph == 4 ? 5'd31 : 5'($urandom_range(1, 4))),
                      ph == 1 ? 5'd0 : 5'($urandom_range(1, 4)),
                      ph == 3 ? 5'd0 : 5'($urandom_range(1, 4)),
                      $urandom_range(0, 1));
            for (int j = 0; j < N_RANDOM / 5; j++) begin
                logic [1:0] f;
                logic [3:0] r;
                f = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 2)) : FUNC_COMPUTE;
                r = (ph == 4) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 5));
                send_item(f, r, 4'($urandom), 16'($urandom));
                if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 30));
                if (j == 4) begin
                    i_start <= 1'b0;
                    @(posedge i_clk);
                    while (expected_results.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("ran %0d items (%0d compute rows), checked %0d results",
                 item_count, compute_count, result_count);
        $display("settings covered transposes, extreme gains, clamped sizes, addend");
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
